// File: sv/ppce_pkg.sv
package ppce_pkg;

    localparam int SLOTS   = 8;
    localparam int CITY_W  = 3;
    localparam int COUNT_W = 4;
    localparam int DIST_W  = 16;
    localparam int TOTAL_W = 19;
    localparam int PATH_W  = SLOTS * CITY_W;
    localparam int CMD_W   = 2;

    localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NEXT    = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd3;

    typedef logic [CITY_W-1:0] t_city;
    typedef t_city [SLOTS-1:0] t_order;

endpackage

// File: sv/permutation_path_cost_enumerator_unit.sv
// Steps through every ordering of the first city_count cities in lexicographic
// order and reports, for each one, the open path cost read from a distance table
// held in a single-port memory. A distance write or a restart keeps busy low.
// A next request updates the ordering in the cycle it is accepted, then reads
// one table entry per cycle for each of the city_count-1 legs while busy is high.
// The result is a transfer that lasts exactly one cycle with o_valid high, in
// the cycle busy falls; the receiver cannot stall it. The first next request
// after reset or a restart returns the identity ordering, and the request after
// the final ordering wraps to it.
module permutation_path_cost_enumerator_unit
    import ppce_pkg::*;
#(
    parameter int MAX_CITIES = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [CITY_W-1:0]   i_from_city,
    input  logic [CITY_W-1:0]   i_to_city,
    input  logic [DIST_W-1:0]   i_distance,
    input  logic                i_cfg_we,
    input  logic [COUNT_W-1:0]  i_cfg_wdata,
    output logic                o_valid,
    output logic [PATH_W-1:0]   o_path,
    output logic [TOTAL_W-1:0]  o_total_distance,
    output logic                o_last_path
);

    localparam int DEPTH = MAX_CITIES * MAX_CITIES;
    localparam int AW    = $clog2(DEPTH);

    logic [DIST_W-1:0] mem [DEPTH];

    logic [COUNT_W-1:0] r_city_count;
    t_order             r_order, n_order;
    logic               r_fresh;
    logic               r_busy;
    logic [COUNT_W-1:0] r_n;
    logic [COUNT_W-1:0] r_step;
    logic               r_rdv;
    logic [DIST_W-1:0]  r_rdata;
    logic [TOTAL_W-1:0] r_acc;
    logic               r_valid;
    logic [PATH_W-1:0]  r_path;
    logic [TOTAL_W-1:0] r_total;
    logic               r_last;

    logic               accept;
    logic [COUNT_W-1:0] act_n;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [TOTAL_W-1:0] sum;
    logic [PATH_W-1:0]  packed_path;

    function automatic logic [AW-1:0] f_addr(input t_city p, input t_city c);
        return AW'(int'(p) * MAX_CITIES + int'(c));
    endfunction

    function automatic t_order f_identity();
        t_order o;
        for (int k = 0; k < SLOTS; k++) begin
            o[k] = CITY_W'(k);
        end
        return o;
    endfunction

    function automatic logic f_desc(input t_order o, input logic [COUNT_W-1:0] n);
        logic d;
        d = 1'b1;
        for (int k = 0; k < SLOTS - 1; k++) begin
            if (COUNT_W'(k + 1) < n && o[k] < o[k+1]) begin
                d = 1'b0;
            end
        end
        return d;
    endfunction

    function automatic t_order f_advance(input t_order o, input logic [COUNT_W-1:0] n);
        t_order             r;
        t_order             s;
        logic               desc;
        t_city              piv;
        t_city              sw;
        t_city              tmp;
        logic [COUNT_W-1:0] src;
        desc = 1'b1;
        piv  = '0;
        sw   = '0;
        for (int k = 0; k < SLOTS - 1; k++) begin
            if (COUNT_W'(k + 1) < n && o[k] < o[k+1]) begin
                desc = 1'b0;
                piv  = CITY_W'(k);
            end
        end
        for (int k = 0; k < SLOTS; k++) begin
            if (COUNT_W'(k) < n && CITY_W'(k) > piv && o[k] > o[piv]) begin
                sw = CITY_W'(k);
            end
        end
        r       = o;
        tmp     = r[piv];
        r[piv]  = r[sw];
        r[sw]   = tmp;
        s       = r;
        for (int p = 0; p < SLOTS; p++) begin
            src = {1'b0, piv} + n - COUNT_W'(p);
            if (CITY_W'(p) > piv && COUNT_W'(p) < n) begin
                r[p] = s[src[CITY_W-1:0]];
            end
        end
        if (desc) begin
            r = f_identity();
        end
        return r;
    endfunction

    assign accept = start && !r_busy;

    always_comb begin
        act_n = r_city_count;
        if (act_n < 4'd2) begin
            act_n = 4'd2;
        end
        if (act_n > COUNT_W'(MAX_CITIES)) begin
            act_n = COUNT_W'(MAX_CITIES);
        end
    end

    assign n_order = r_fresh ? r_order : f_advance(r_order, act_n);

    assign wr_en   = accept && i_cmd == CMD_WRITE
                     && int'(i_from_city) < MAX_CITIES && int'(i_to_city) < MAX_CITIES;
    assign wr_addr = f_addr(i_from_city, i_to_city);

    assign rd_en   = r_busy && r_step < r_n;
    assign rd_addr = f_addr(r_order[r_step[CITY_W-1:0] - 3'd1], r_order[r_step[CITY_W-1:0]]);

    assign sum = r_acc + TOTAL_W'(r_rdata);

    always_comb begin
        for (int k = 0; k < SLOTS; k++) begin
            packed_path[k*CITY_W +: CITY_W] = (COUNT_W'(k) < r_n) ? r_order[k] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_distance;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_city_count <= COUNT_RESET;
            r_order      <= f_identity();
            r_fresh      <= 1'b1;
            r_busy       <= 1'b0;
            r_n          <= 4'd2;
            r_step       <= '0;
            r_rdv        <= 1'b0;
            r_acc        <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            r_rdv   <= rd_en;
            if (i_cfg_we) begin
                r_city_count <= i_cfg_wdata;
            end
            if (accept && i_cmd == CMD_RESTART) begin
                r_order <= f_identity();
                r_fresh <= 1'b1;
            end
            if (accept && i_cmd == CMD_NEXT) begin
                r_order <= n_order;
                r_fresh <= 1'b0;
                r_busy  <= 1'b1;
                r_n     <= act_n;
                r_step  <= 4'd1;
                r_acc   <= '0;
            end
            if (rd_en) begin
                r_step <= r_step + 4'd1;
            end
            if (r_rdv) begin
                r_acc <= sum;
            end
            if (r_busy && r_step == r_n && r_rdv) begin
                r_busy  <= 1'b0;
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && r_step == r_n && r_rdv) begin
            r_path  <= packed_path;
            r_total <= sum;
            r_last  <= f_desc(r_order, r_n);
        end
    end

    assign busy             = r_busy;
    assign o_valid          = r_valid;
    assign o_path           = r_path;
    assign o_total_distance = r_total;
    assign o_last_path      = r_last;

endmodule

// File: sv/ppce_checker.sv
module ppce_checker
    import ppce_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic [CMD_W-1:0] i_cmd,
    input logic             o_valid
);

    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without a preceding busy cycle");

    a_next_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd == CMD_NEXT) |=> busy)
        else $error("next request did not raise busy");

    a_short_cmd_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd == CMD_WRITE || i_cmd == CMD_RESTART)) |=> !busy)
        else $error("write or restart raised busy");

    a_fall_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy fell without a result transfer");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe lasted more than one cycle");

endmodule

bind permutation_path_cost_enumerator_unit ppce_checker u_ppce_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_cmd   (i_cmd),
    .o_valid (o_valid)
);

// File: dv/ppce_path_checker.sv
module ppce_path_checker
    import ppce_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [CITY_W-1:0]   i_from_city,
    input  logic [CITY_W-1:0]   i_to_city,
    input  logic [DIST_W-1:0]   i_distance,
    input  logic                i_cfg_we,
    input  logic [COUNT_W-1:0]  i_cfg_wdata,
    input  logic                o_valid,
    input  logic [PATH_W-1:0]   o_path,
    input  logic [TOTAL_W-1:0]  o_total_distance,
    input  logic                o_last_path,
    output int                  o_error_count,
    output int                  o_outstanding,
    output int                  o_checked_count,
    output int                  o_final_count
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [PATH_W-1:0]  path;
        logic [TOTAL_W-1:0] total;
        logic               last;
    } t_path_result;

    logic [DIST_W-1:0]  dist_tab [SLOTS][SLOTS];
    t_order             order;
    logic               fresh;
    logic [COUNT_W-1:0] city_count;
    t_path_result       expected_paths [$];
    int                 errors = 0;
    int                 checked = 0;
    int                 finals = 0;

    function automatic int unsigned cities_in_use(logic [COUNT_W-1:0] c);
        if (c < 2) begin
            return 2;
        end
        if (c > SLOTS) begin
            return SLOTS;
        end
        return 32'(c);
    endfunction

    function automatic t_order identity_order();
        t_order o;
        for (int k = 0; k < SLOTS; k++) begin
            o[k] = t_city'(k);
        end
        return o;
    endfunction

    function automatic bit is_falling(t_order o, int unsigned n);
        for (int k = 0; k + 1 < n; k++) begin
            if (o[k] < o[k+1]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Standard lexicographic successor on the first n positions; the final
    // ordering wraps back to the identity.
    function automatic t_order successor(t_order o, int unsigned n);
        int    i;
        int    j;
        int    lo;
        int    hi;
        t_city t;
        if (is_falling(o, n)) begin
            return identity_order();
        end
        i = n - 2;
        while (o[i] >= o[i+1]) begin
            i--;
        end
        j = n - 1;
        while (o[j] <= o[i]) begin
            j--;
        end
        t = o[i];
        o[i] = o[j];
        o[j] = t;
        lo = i + 1;
        hi = n - 1;
        while (lo < hi) begin
            t = o[lo];
            o[lo] = o[hi];
            o[hi] = t;
            lo++;
            hi--;
        end
        return o;
    endfunction

    function automatic t_path_result score(t_order o, int unsigned n);
        t_path_result       r;
        logic [TOTAL_W-1:0] sum;
        r.path = '0;
        sum = '0;
        for (int k = 0; k < n; k++) begin
            r.path[k*CITY_W +: CITY_W] = o[k];
            if (k > 0) begin
                sum = sum + TOTAL_W'(dist_tab[o[k-1]][o[k]]);
            end
        end
        r.total = sum;
        r.last = is_falling(o, n);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_path_result want;
        int unsigned  n;
        if (!i_rst_n) begin
            order = identity_order();
            fresh = 1'b1;
            city_count = COUNT_RESET;
            expected_paths.delete();
        end else begin
            if (o_valid) begin
                if (expected_paths.size() == 0) begin
                    $error("path result transfer with no path expected");
                    errors++;
                end else begin
                    want = expected_paths.pop_front();
                    checked++;
                    if (want.last) begin
                        finals++;
                    end
                    if (o_path !== want.path) begin
                        $error("path: expected %h, got %h", want.path, o_path);
                        errors++;
                    end
                    if (o_total_distance !== want.total) begin
                        $error("total_distance: expected %0d, got %0d",
                               want.total, o_total_distance);
                        errors++;
                    end
                    if (o_last_path !== want.last) begin
                        $error("last_path: expected %b, got %b", want.last, o_last_path);
                        errors++;
                    end
                end
            end
            if (i_cfg_we) begin
                city_count = i_cfg_wdata;
            end
            if (start && !busy) begin
                case (i_cmd)
                    CMD_WRITE: begin
                        dist_tab[i_from_city][i_to_city] = i_distance;
                    end
                    CMD_RESTART: begin
                        order = identity_order();
                        fresh = 1'b1;
                    end
                    CMD_NEXT: begin
                        n = cities_in_use(city_count);
                        if (fresh) begin
                            fresh = 1'b0;
                        end else begin
                            order = successor(order, n);
                        end
                        expected_paths = {expected_paths, score(order, n)};
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_error_count <= errors;
        o_outstanding <= expected_paths.size();
        o_checked_count <= checked;
        o_final_count <= finals;
    end

endmodule

// File: dv/tb_permutation_path_cost_enumerator_unit.sv
module tb_permutation_path_cost_enumerator_unit
    import ppce_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS = 60;
    localparam int NUM_PHASES = 12;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [CMD_W-1:0]   cmd = CMD_WRITE;
    logic [CITY_W-1:0]  from_city = '0;
    logic [CITY_W-1:0]  to_city = '0;
    logic [DIST_W-1:0]  distance = '0;
    logic               cfg_we = 1'b0;
    logic [COUNT_W-1:0] cfg_wdata = '0;
    logic               valid;
    logic [PATH_W-1:0]  path;
    logic [TOTAL_W-1:0] total_distance;
    logic               last_path;

    int error_count;
    int outstanding;
    int checked_count;
    int final_count;
    int transfers = 0;
    int stall_cycles = 0;

    int phase_counts [NUM_PHASES] = '{8, 2, 0, 15, 1, 9, 4, 5, 6, 7, 2, 3};
    int idle_pct [4] = '{0, 59, 0, 6};

    always #5ns clk = ~clk;

    permutation_path_cost_enumerator_unit i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .start            (start),
        .busy             (busy),
        .i_cmd            (cmd),
        .i_from_city      (from_city),
        .i_to_city        (to_city),
        .i_distance       (distance),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .o_valid          (valid),
        .o_path           (path),
        .o_total_distance (total_distance),
        .o_last_path      (last_path)
    );

    ppce_path_checker i_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .start            (start),
        .busy             (busy),
        .i_cmd            (cmd),
        .i_from_city      (from_city),
        .i_to_city        (to_city),
        .i_distance       (distance),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .o_valid          (valid),
        .o_path           (path),
        .o_total_distance (total_distance),
        .o_last_path      (last_path),
        .o_error_count    (error_count),
        .o_outstanding    (outstanding),
        .o_checked_count  (checked_count),
        .o_final_count    (final_count)
    );

    always @(posedge clk) begin
        if ((start && !busy) || valid === 1'b1) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic send(logic [CMD_W-1:0] c, logic [CITY_W-1:0] f, logic [CITY_W-1:0] t,
                        logic [DIST_W-1:0] d);
        start <= 1'b1;
        cmd <= c;
        from_city <= f;
        to_city <= t;
        distance <= d;
        do begin
            @(posedge clk);
        end while (busy);
        transfers++;
    endtask

    task automatic drain();
        start <= 1'b0;
        do begin
            @(posedge clk);
        end while (outstanding != 0 || busy);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_count(logic [COUNT_W-1:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [DIST_W-1:0] rand_distance();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return '0;
        end
        if (r == 1) begin
            return '1;
        end
        return DIST_W'($urandom_range(0, 65535));
    endfunction

    task automatic random_item();
        int unsigned      r;
        logic [CMD_W-1:0] c;
        r = $urandom_range(0, 99);
        if (r < 62) begin
            c = CMD_NEXT;
        end else if (r < 84) begin
            c = CMD_WRITE;
        end else if (r < 92) begin
            c = CMD_RESTART;
        end else begin
            c = CMD_UNUSED;
        end
        send(c, CITY_W'($urandom_range(0, 7)), CITY_W'($urandom_range(0, 7)), rand_distance());
    endtask

    initial begin
        int pct;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every entry is loaded before any path is asked for, so no read
        // ever lands on an unwritten entry.
        for (int f = 0; f < SLOTS; f++) begin
            for (int t = 0; t < SLOTS; t++) begin
                send(CMD_WRITE, CITY_W'(f), CITY_W'(t), '1);
            end
        end

        send(CMD_NEXT, '0, '0, '0);
        send(CMD_WRITE, 3'd1, 3'd0, '0);
        send(CMD_WRITE, 3'd7, 3'd0, 16'h0001);
        send(CMD_WRITE, 3'd0, 3'd7, 16'h8000);
        repeat (6) send(CMD_NEXT, '0, '0, '0);
        send(CMD_RESTART, '0, '0, '0);
        send(CMD_NEXT, '0, '0, '0);
        send(CMD_UNUSED, 3'd7, 3'd7, '1);
        send(CMD_NEXT, 3'd7, 3'd7, '1);
        set_count(4'd8);
        send(CMD_NEXT, '0, '0, '0);
        send(CMD_RESTART, '0, '0, '0);
        send(CMD_NEXT, '0, '0, '0);

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_count(COUNT_W'(phase_counts[p]));
            pct = idle_pct[p % 4];
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 99) < 2) begin
                    drain();
                end
                while ($urandom_range(0, 99) < pct) begin
                    start <= 1'b0;
                    @(posedge clk);
                end
                random_item();
            end
        end

        drain();
        repeat (8) @(posedge clk);
        $display("Sent %0d transfers over %0d city count settings; checked %0d paths,",
                 transfers, NUM_PHASES + 2, checked_count);
        $display("%0d of them final orderings before a wrap.", final_count);
        if (error_count == 0 && outstanding == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
